@@ sv/tsl_pkg.sv @@
`timescale 1ns / 1ps

package tsl_pkg;

    // Fixed configuration of the oscillator
    localparam int MAX_BLOCK       = 4096;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PB16            = PHASE_BITS - 16;

    // Field widths
    localparam int N_W      = 13;
    localparam int BPM_W    = 26;
    localparam int PPQ_W    = 48;
    localparam int OUT_W    = 17;
    localparam int RATE_W   = 32;
    localparam int OFS_W    = 16;
    localparam int FS_W     = 19;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 32;

    // Datapath widths
    localparam int FS60_W   = 25;              // 60 * fs
    localparam int PER_W    = 10;              // period in 1/24 beat
    localparam int DEN_W    = FS60_W + PER_W;  // 60 * fs * period
    localparam int SPAN_W   = PER_W + 16;      // period in 1/24 beat, Q.16
    localparam int BPM24_W  = BPM_W + 5;       // bpm * 24
    localparam int ADVP_W   = BPM_W + N_W;     // bpm * (n - 1)
    localparam int SUM_W    = PPQ_W + 1;       // ppq + advance
    localparam int DIVD_W   = (RATE_W + PB16 > 54) ? RATE_W + PB16 : 54;
    localparam int DVSR_W   = DEN_W;
    localparam int CNT_W    = $clog2(DIVD_W + 1);

    localparam logic [FS_W-1:0] FS_DEFAULT = FS_W'(48000);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ENABLED    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WAVE_SHAPE = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_TEMPO_SYNC = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_NOTE_DIV   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_NOTE_FLAV  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_FREE_RATE  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_PHASE_OFS  = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SAMPLE_RT  = 3'd7;

    // Wave shapes
    localparam logic [2:0] SHAPE_OFF      = 3'd0;
    localparam logic [2:0] SHAPE_SINE     = 3'd1;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
    localparam logic [2:0] SHAPE_SAW      = 3'd3;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd4;

    // Note flavors and the division code that falls back to one beat
    localparam logic [1:0] FLAVOR_TRIPLET = 2'd1;
    localparam logic [1:0] FLAVOR_DOTTED  = 2'd2;
    localparam logic [2:0] DIV_BEAT_ALIAS = 3'd7;

    // Divider operand select
    typedef enum logic [2:0] {
        DS_FREE  = 3'd0,
        DS_TEMPO = 3'd1,
        DS_ADV   = 3'd2,
        DS_MOD   = 3'd3,
        DS_PHASE = 3'd4
    } div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     prep;
        logic     den;
        logic     div_start;
        div_sel_t div_sel;
        logic     inc_mul;
        logic     acc;
        logic     adv_mul;
        logic     pos;
        logic     scale;
        logic     fix;
        logic     host;
        logic     shape;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_reset;
        logic active;
        logic host_lock;
        logic tempo_run;
        logic n_zero;
        logic div_done;
        logic out_free;
    } sts_t;

    // Quarter-wave sine table
    localparam int SINE_QBITS = SINE_TABLE_BITS - 2;
    localparam int SINE_QLEN  = 1 << SINE_QBITS;

    typedef logic [15:0] sine_lut_t [SINE_QLEN];

    // Q30 scaling with rounding toward zero
    function automatic longint q30_scale(longint v);
        return (v < 0) ? -((-v) >>> 30) : (v >>> 30);
    endfunction

    // Half amplitude at quarter-wave position x (Q30), odd degree-9 polynomial
    function automatic logic [15:0] quarter_sine(longint x);
        longint q30;
        longint s;
        longint r;
        q30 = longint'(1) << 30;
        s = q30_scale(x * x);
        r = 172271;
        r = -5026990 + q30_scale(r * s);
        r = 85569270 + q30_scale(r * s);
        r = -693598670 + q30_scale(r * s);
        r = 1686629713 + q30_scale(r * s);
        r = q30_scale(r * x);
        if (r < 0)
        begin
            r = 0;
        end
        if (r > q30)
        begin
            r = q30;
        end
        return 16'((r + (longint'(1) << 14)) >>> 15);
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        for (int i = 0; i < SINE_QLEN; i++)
        begin
            lut[i] = quarter_sine(longint'(i) <<< (30 - SINE_QBITS));
        end
        return lut;
    endfunction

    localparam sine_lut_t   SINE_LUT = build_sine_lut();
    localparam logic [15:0] SINE_TOP = quarter_sine(longint'(1) <<< 30);

endpackage

@@ sv/tsl_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module tsl_div
    import tsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic [DVSR_W-1:0] remainder,
    output logic              done
);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [DVSR_W:0]   shifted;
    logic [DVSR_W+1:0] diff;

    // One trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[DVSR_W+1])
            begin
                rem_next = shifted[DVSR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DVSR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = !busy_reg;

endmodule

@@ sv/tsl_dp.sv @@
`timescale 1ns / 1ps

module tsl_dp
    import tsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               req_type,
    input  logic [N_W-1:0]     sample_count,
    input  logic               host_playing,
    input  logic [BPM_W-1:0]   host_bpm_q16,
    input  logic signed [PPQ_W-1:0] host_ppq_q16,
    input  logic               cfg_valid,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   lfo_value
);

    // Configuration registers
    logic              enabled_reg;
    logic [2:0]        wave_shape_reg;
    logic              tempo_sync_reg;
    logic [2:0]        note_div_reg;
    logic [1:0]        note_flav_reg;
    logic [RATE_W-1:0] free_rate_reg;
    logic [OFS_W-1:0]  phase_ofs_reg;
    logic [FS_W-1:0]   sample_rt_reg;

    // Request registers
    logic              req_reg;
    logic [N_W-1:0]    n_reg;
    logic              playing_reg;
    logic [BPM_W-1:0]  bpm_reg;
    logic [PPQ_W-1:0]  ppq_reg;

    // Work registers
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [FS60_W-1:0]     fs60_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [ADVP_W-1:0]     advp_reg;
    logic [PHASE_BITS-1:0] incn_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [SPAN_W-1:0]     r_reg;
    logic [OUT_W-1:0]      lfo_value_reg;
    logic                  out_valid_reg, out_valid_next;

    logic [FS_W-1:0]   fs_eff;
    logic [PER_W-1:0]  per;
    logic [SPAN_W-1:0] span;
    logic [N_W-1:0]    n_sat;
    logic              sync;

    logic [DIVD_W-1:0] div_dvd;
    logic [DVSR_W-1:0] div_dvs;
    logic [DIVD_W-1:0] div_quo;
    logic [DVSR_W-1:0] div_rem;
    logic              div_done;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            wave_shape_reg <= SHAPE_OFF;
            tempo_sync_reg <= 1'b0;
            note_div_reg   <= 3'd2;
            note_flav_reg  <= 2'd0;
            free_rate_reg  <= RATE_W'(65536);
            phase_ofs_reg  <= '0;
            sample_rt_reg  <= FS_DEFAULT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                CFG_WAVE_SHAPE: wave_shape_reg <= cfg_data[2:0];
                CFG_TEMPO_SYNC: tempo_sync_reg <= cfg_data[0];
                CFG_NOTE_DIV:   note_div_reg   <= cfg_data[2:0];
                CFG_NOTE_FLAV:  note_flav_reg  <= cfg_data[1:0];
                CFG_FREE_RATE:  free_rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_PHASE_OFS:  phase_ofs_reg  <= cfg_data[OFS_W-1:0];
                CFG_SAMPLE_RT:  sample_rt_reg  <= cfg_data[FS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Derived configuration
    always_comb
    begin
        logic [2:0] shift;
        logic [3:0] base;
        fs_eff = (sample_rt_reg == '0) ? FS_DEFAULT : sample_rt_reg;
        shift  = (note_div_reg == DIV_BEAT_ALIAS) ? 3'd2 : note_div_reg;
        case (note_flav_reg)
            FLAVOR_TRIPLET: base = 4'd4;
            FLAVOR_DOTTED:  base = 4'd9;
            default:        base = 4'd6;
        endcase
        per  = PER_W'(base) << shift;
        span = {per, 16'h0000};
        n_sat = (sample_count > N_W'(MAX_BLOCK)) ? N_W'(MAX_BLOCK) : sample_count;
        sync  = tempo_sync_reg && (bpm_reg != '0);
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req_type;
            n_reg       <= n_sat;
            playing_reg <= host_playing;
            bpm_reg     <= host_bpm_q16;
            ppq_reg     <= host_ppq_q16;
        end
    end

    // Divider operands
    always_comb
    begin
        logic [BPM24_W-1:0] bpm24;
        logic [DIVD_W-1:0]  mag_ext;
        bpm24   = (BPM24_W'(bpm_reg) << 4) + (BPM24_W'(bpm_reg) << 3);
        mag_ext = DIVD_W'(mag_reg);
        case (cmd.div_sel)
            DS_FREE:
            begin
                div_dvd = DIVD_W'(free_rate_reg) << PB16;
                div_dvs = DVSR_W'(fs_eff);
            end
            DS_TEMPO:
            begin
                div_dvd = DIVD_W'(bpm24) << PB16;
                div_dvs = den_reg;
            end
            DS_ADV:
            begin
                div_dvd = DIVD_W'(advp_reg);
                div_dvs = DVSR_W'(fs60_reg);
            end
            DS_MOD:
            begin
                div_dvd = (mag_ext << 4) + (mag_ext << 3);
                div_dvs = DVSR_W'(span);
            end
            DS_PHASE:
            begin
                div_dvd = DIVD_W'(r_reg) << PB16;
                div_dvs = DVSR_W'(per);
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = DVSR_W'(1);
            end
        endcase
    end

    tsl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Products, position and remainder fix-up
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            fs60_reg <= FS60_W'(fs_eff) * FS60_W'(60);
        end
        if (cmd.den)
        begin
            den_reg <= DEN_W'(fs60_reg) * DEN_W'(per);
        end
        if (cmd.adv_mul)
        begin
            advp_reg <= ADVP_W'(bpm_reg) * ADVP_W'(n_reg - 1'b1);
        end
        if (cmd.inc_mul)
        begin
            incn_reg <= PHASE_BITS'(div_quo[PHASE_BITS-1:0] * (PHASE_BITS + N_W)'(n_reg));
        end
        if (cmd.pos)
        begin
            sum_reg <= {ppq_reg[PPQ_W-1], ppq_reg} + SUM_W'(div_quo[ADVP_W-1:0]);
        end
        if (cmd.scale)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        end
        if (cmd.fix)
        begin
            if (neg_reg && (div_rem[SPAN_W-1:0] != '0))
            begin
                r_reg <= span - div_rem[SPAN_W-1:0];
            end
            else
            begin
                r_reg <= div_rem[SPAN_W-1:0];
            end
        end
    end

    // Phase accumulator
    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.prep && req_reg)
        begin
            phase_next = '0;
        end
        else if (cmd.acc)
        begin
            phase_next = phase_reg + incn_reg;
        end
        else if (cmd.host)
        begin
            phase_next = div_quo[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Wave shaping
    logic [OUT_W-1:0] shaped;
    always_comb
    begin
        logic [PHASE_BITS-1:0]      p;
        logic [SINE_TABLE_BITS-1:0] k;
        logic [SINE_QBITS:0]        spos;
        logic [15:0]                m;
        logic [16:0]                t;
        p    = phase_reg + (PHASE_BITS'(phase_ofs_reg) << PB16);
        k    = p[PHASE_BITS-1 -: SINE_TABLE_BITS];
        spos = k[SINE_TABLE_BITS-2] ? ((SINE_QBITS+1)'(SINE_QLEN) - {1'b0, k[SINE_QBITS-1:0]})
                                    : {1'b0, k[SINE_QBITS-1:0]};
        m    = spos[SINE_QBITS] ? SINE_TOP : SINE_LUT[spos[SINE_QBITS-1:0]];
        t    = p[PHASE_BITS-1 -: 17];
        case (wave_shape_reg)
            SHAPE_SINE:
                shaped = k[SINE_TABLE_BITS-1] ? (OUT_W'(32768) - OUT_W'(m))
                                              : (OUT_W'(32768) + OUT_W'(m));
            SHAPE_TRIANGLE:
                shaped = t[16] ? (OUT_W'(131072) - t) : t;
            SHAPE_SAW:
                shaped = {1'b0, p[PHASE_BITS-1 -: 16]};
            SHAPE_SQUARE:
                shaped = p[PHASE_BITS-1] ? '0 : OUT_W'(65536);
            default:
                shaped = '0;
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.shape)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shape)
        begin
            lfo_value_reg <= (req_reg || !sts.active) ? '0 : shaped;
        end
    end

    // Status
    always_comb
    begin
        sts.req_reset = req_reg;
        sts.active    = enabled_reg && (wave_shape_reg inside {[SHAPE_SINE:SHAPE_SQUARE]});
        sts.host_lock = sync && playing_reg;
        sts.tempo_run = sync && !playing_reg;
        sts.n_zero    = (n_reg == '0);
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign lfo_value = lfo_value_reg;

endmodule

@@ sv/tsl_ctrl.sv @@
`timescale 1ns / 1ps

module tsl_ctrl
    import tsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_PREP   = 20'h00002,
        S_DEN    = 20'h00004,
        S_DIVF   = 20'h00008,
        S_DIVT   = 20'h00010,
        S_WAITI  = 20'h00020,
        S_INCMUL = 20'h00040,
        S_ACC    = 20'h00080,
        S_ADVMUL = 20'h00100,
        S_DIVA   = 20'h00200,
        S_WAITA  = 20'h00400,
        S_POS    = 20'h00800,
        S_SCALE  = 20'h01000,
        S_DIVM   = 20'h02000,
        S_WAITM  = 20'h04000,
        S_FIX    = 20'h08000,
        S_DIVP   = 20'h10000,
        S_WAITP  = 20'h20000,
        S_HOST   = 20'h40000,
        S_SHAPE  = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DS_FREE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            // Pick the path for this request
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (sts.req_reset || !sts.active)
                begin
                    state_next = S_SHAPE;
                end
                else if (sts.host_lock)
                begin
                    state_next = sts.n_zero ? S_SHAPE : S_ADVMUL;
                end
                else if (sts.tempo_run)
                begin
                    state_next = S_DEN;
                end
                else
                begin
                    state_next = S_DIVF;
                end
            end
            S_DEN:
            begin
                cmd.den    = 1'b1;
                state_next = S_DIVT;
            end
            // Free-running or tempo increment
            S_DIVF:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_FREE;
                state_next    = S_WAITI;
            end
            S_DIVT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_TEMPO;
                state_next    = S_WAITI;
            end
            S_WAITI:
            begin
                if (sts.div_done)
                begin
                    state_next = S_INCMUL;
                end
            end
            S_INCMUL:
            begin
                cmd.inc_mul = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_SHAPE;
            end
            // Host-locked phase
            S_ADVMUL:
            begin
                cmd.adv_mul = 1'b1;
                state_next  = S_DIVA;
            end
            S_DIVA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_ADV;
                state_next    = S_WAITA;
            end
            S_WAITA:
            begin
                if (sts.div_done)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                cmd.pos    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_MOD;
                state_next    = S_WAITM;
            end
            S_WAITM:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_DIVP;
            end
            S_DIVP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_PHASE;
                state_next    = S_WAITP;
            end
            S_WAITP:
            begin
                if (sts.div_done)
                begin
                    state_next = S_HOST;
                end
            end
            S_HOST:
            begin
                cmd.host   = 1'b1;
                state_next = S_SHAPE;
            end
            // Hand the value to the output register once it is free
            S_SHAPE:
            begin
                cmd.shape = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/tempo_synced_lfo.sv @@
`timescale 1ns / 1ps

// Tempo-synced LFO, one value per audio block.
// Requests come in on in_valid/in_ready with req_type, sample_count, host
// transport and tempo; each request gives exactly one lfo_value (UQ1.16) on
// out_valid/out_ready. Registers must be written through cfg_valid/cfg_index/
// cfg_data only while no request is in flight; the block itself does not
// enforce this. cfg_ready is always high.
// A phase reset, a disabled oscillator or a host-locked block of zero samples
// goes straight to the output register; the free and tempo rates take one
// division and the host-locked position takes three.
// The divider is bit-serial, one quotient bit per cycle over DIVD_W bits;
// one request is processed at a time.
// A new request is accepted as soon as the previous value sits in the output
// register, even if the receiver has not taken it yet. If the receiver still
// stalls when the next value is ready, processing waits for the register.
// Reset clears the phase to zero and loads the register defaults.
module tempo_synced_lfo
    import tsl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [N_W-1:0]          sample_count,
    input  logic                    host_playing,
    input  logic [BPM_W-1:0]        host_bpm_q16,
    input  logic signed [PPQ_W-1:0] host_ppq_q16,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [OUT_W-1:0]        lfo_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CIDX_W-1:0]       cfg_index,
    input  logic [CDATA_W-1:0]      cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tsl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .sample_count (sample_count),
        .host_playing (host_playing),
        .host_bpm_q16 (host_bpm_q16),
        .host_ppq_q16 (host_ppq_q16),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lfo_value    (lfo_value)
    );

endmodule

@@ sv/tsl_checker.sv @@
`timescale 1ns / 1ps

module tsl_checker
    import tsl_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [OUT_W-1:0]        lfo_value
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lfo_value))
        else $error("result changed while stalled");

    // Value never exceeds one
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lfo_value <= OUT_W'(65536))
        else $error("lfo_value above one");

    // One request in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // A fresh result leaves the block ready for the next request
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("not ready after result");

endmodule

bind tempo_synced_lfo tsl_checker u_tsl_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tsl_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 400;
    localparam int PHASE_ITEMS = 210;

    typedef struct {
        bit             rst_phase;
        bit [N_W-1:0]   n;
        bit             playing;
        bit [BPM_W-1:0] bpm;
        bit [PPQ_W-1:0] ppq;
    } lfo_req_t;

    typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [CIDX_W-1:0] idx;
        bit [CDATA_W-1:0]  data;
        lfo_req_t          rq;
        bit                has_exp;
        bit [OUT_W-1:0]    exp_val;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [N_W-1:0] sample_count;
    logic host_playing;
    logic [BPM_W-1:0] host_bpm_q16;
    logic signed [PPQ_W-1:0] host_ppq_q16;
    logic out_valid;
    logic out_ready;
    logic [OUT_W-1:0] lfo_value;
    logic cfg_valid;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CDATA_W-1:0] cfg_data;

    // predictor copy of registers and phase
    bit          m_enabled;
    bit [2:0]    m_shape;
    bit          m_sync;
    bit [2:0]    m_div;
    bit [1:0]    m_flavor;
    bit [31:0]   m_rate;
    bit [15:0]   m_offset;
    bit [18:0]   m_fs;
    bit [31:0]   m_phase;

    bit [OUT_W-1:0] lfo_expected[$];
    stim_row_t      directed[$];
    int             errors;
    int             cycles;
    bit             send_idle;
    bit             recv_stall;

    tempo_synced_lfo u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .sample_count (sample_count),
        .host_playing (host_playing),
        .host_bpm_q16 (host_bpm_q16),
        .host_ppq_q16 (host_ppq_q16),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lfo_value    (lfo_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // half amplitude of sine at quarter-wave position x (Q30), UQ1.15
    function automatic longint half_sine(longint x);
        longint one;
        longint sq;
        longint acc;
        one = longint'(1) << 30;
        sq = (x * x) / one;
        acc = 172271;
        acc = -5026990 + (acc * sq) / one;
        acc = 85569270 + (acc * sq) / one;
        acc = -693598670 + (acc * sq) / one;
        acc = 1686629713 + (acc * sq) / one;
        acc = (acc * x) / one;
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > one)
        begin
            acc = one;
        end
        return (acc + (longint'(1) << 14)) >>> 15;
    endfunction

    function automatic bit [OUT_W-1:0] wave_of(bit [31:0] p);
        bit [9:0]  k;
        bit [8:0]  pos;
        bit [16:0] t;
        longint    m;
        k = p[31:22];
        pos = k[8] ? 9'd256 - 9'(k[7:0]) : 9'(k[7:0]);
        t = p[31:15];
        case (m_shape)
            SHAPE_SINE:
            begin
                m = half_sine(longint'(pos) << 22);
                return k[9] ? OUT_W'(32768 - m) : OUT_W'(32768 + m);
            end
            SHAPE_TRIANGLE: return t[16] ? OUT_W'(131072 - t) : OUT_W'(t);
            SHAPE_SAW:      return OUT_W'(p[31:16]);
            SHAPE_SQUARE:   return p[31] ? '0 : OUT_W'(65536);
            default:        return '0;
        endcase
    endfunction

    // advance the phase for one block and shape it
    function automatic bit [OUT_W-1:0] lfo_block(lfo_req_t rq);
        bit [63:0] fs;
        bit [63:0] n;
        bit [63:0] per;
        bit [63:0] inc;
        bit [2:0]  sh;
        longint    pos;
        longint    adv;
        longint    span;
        longint    rem;
        fs = (m_fs == 0) ? 64'd48000 : 64'(m_fs);
        n = (rq.n > MAX_BLOCK) ? 64'(MAX_BLOCK) : 64'(rq.n);
        if (rq.rst_phase)
        begin
            m_phase = '0;
            return '0;
        end
        if (!m_enabled || m_shape == SHAPE_OFF || m_shape > SHAPE_SQUARE)
        begin
            return '0;
        end
        sh = (m_div == DIV_BEAT_ALIAS) ? 3'd2 : m_div;
        per = (m_flavor == FLAVOR_TRIPLET) ? (64'd4 << sh) :
              (m_flavor == FLAVOR_DOTTED)  ? (64'd9 << sh) : (64'd6 << sh);
        if (m_sync && rq.bpm != 0)
        begin
            if (rq.playing)
            begin
                if (n != 0)
                begin
                    pos = longint'($signed(rq.ppq));
                    adv = longint'((64'(rq.bpm) * (n - 1)) / (60 * fs));
                    span = longint'(per << 16);
                    rem = ((pos + adv) * 24) % span;
                    if (rem < 0)
                    begin
                        rem += span;
                    end
                    m_phase = 32'((64'(rem) << 16) / per);
                end
            end
            else
            begin
                inc = ((64'(rq.bpm) * 24) << 16) / (60 * fs * per);
                m_phase = 32'(64'(m_phase) + inc * n);
            end
        end
        else
        begin
            inc = ((64'(m_rate) / fs) << 16) + (((64'(m_rate) % fs) << 16) / fs);
            m_phase = 32'(64'(m_phase) + inc * n);
        end
        return wave_of(m_phase + {m_offset, 16'h0});
    endfunction

    // register write as seen by the block
    task automatic apply_reg(logic [CIDX_W-1:0] idx, bit [CDATA_W-1:0] d);
        case (idx)
            CFG_ENABLED:    m_enabled = d[0];
            CFG_WAVE_SHAPE: m_shape = d[2:0];
            CFG_TEMPO_SYNC: m_sync = d[0];
            CFG_NOTE_DIV:   m_div = d[2:0];
            CFG_NOTE_FLAV:  m_flavor = d[1:0];
            CFG_FREE_RATE:  m_rate = d;
            CFG_PHASE_OFS:  m_offset = d[15:0];
            default:        m_fs = d[18:0];
        endcase
    endtask

    // monitor: predict on request, compare on result, track register writes
    always @(posedge clk)
    begin
        lfo_req_t rq;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                rq.rst_phase = req_type;
                rq.n = sample_count;
                rq.playing = host_playing;
                rq.bpm = host_bpm_q16;
                rq.ppq = host_ppq_q16;
                lfo_expected.push_back(lfo_block(rq));
            end
            if (out_valid && out_ready)
            begin
                if (lfo_expected.size() == 0)
                begin
                    report_mismatch("unexpected lfo_value", lfo_value, -1);
                end
                else if (lfo_value !== lfo_expected[0])
                begin
                    report_mismatch("lfo_value", lfo_value, lfo_expected.pop_front());
                end
                else
                begin
                    void'(lfo_expected.pop_front());
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= recv_stall ? ($urandom_range(99) >= 56) : 1'b1;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold valid until taken; when idling, first lower it for a random gap
    task automatic send_request(lfo_req_t rq);
        if (send_idle && $urandom_range(99) < 56)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq.rst_phase;
        sample_count <= rq.n;
        host_playing <= rq.playing;
        host_bpm_q16 <= rq.bpm;
        host_ppq_q16 <= rq.ppq;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lfo_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, bit [CDATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_cfg(logic [CIDX_W-1:0] idx, bit [CDATA_W-1:0] d);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = d;
        row.rq = '{rst_phase: 1'b0, n: '0, playing: 1'b0, bpm: '0, ppq: '0};
        row.has_exp = 1'b0;
        row.exp_val = '0;
        directed.push_back(row);
    endfunction

    function automatic void add_req(bit rp, bit [N_W-1:0] n, bit pl, bit [BPM_W-1:0] bpm,
                                    bit [PPQ_W-1:0] ppq, bit has_exp, bit [OUT_W-1:0] ev);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.idx = '0;
        row.data = '0;
        row.rq = '{rst_phase: rp, n: n, playing: pl, bpm: bpm, ppq: ppq};
        row.has_exp = has_exp;
        row.exp_val = ev;
        directed.push_back(row);
    endfunction

    task automatic random_settings();
        write_reg(CFG_ENABLED, ($urandom_range(9) != 0));
        write_reg(CFG_WAVE_SHAPE, ($urandom_range(9) == 0) ? $urandom_range(7) :
                                  $urandom_range(1, 4));
        write_reg(CFG_TEMPO_SYNC, $urandom_range(1));
        write_reg(CFG_NOTE_DIV, $urandom_range(7));
        write_reg(CFG_NOTE_FLAV, $urandom_range(3));
        case ($urandom_range(3))
            0:       write_reg(CFG_FREE_RATE, $urandom());
            1:       write_reg(CFG_FREE_RATE, 32'hFFFF_FFFF);
            default: write_reg(CFG_FREE_RATE, $urandom_range(20 << 16));
        endcase
        write_reg(CFG_PHASE_OFS, $urandom_range(16'hFFFF));
        case ($urandom_range(5))
            0:       write_reg(CFG_SAMPLE_RT, 0);
            1:       write_reg(CFG_SAMPLE_RT, 384000);
            2:       write_reg(CFG_SAMPLE_RT, $urandom_range(19'h7FFFF));
            default: write_reg(CFG_SAMPLE_RT, ($urandom_range(1)) ? 44100 : 96000);
        endcase
        end_writes();
    endtask

    function automatic lfo_req_t random_request();
        lfo_req_t rq;
        int       pick;
        rq.rst_phase = ($urandom_range(99) < 5);
        pick = $urandom_range(99);
        rq.n = (pick < 10) ? '0 : (pick < 80) ? N_W'($urandom_range(1024)) :
               (pick < 95) ? N_W'($urandom_range(1, 4096)) : N_W'($urandom_range(4097, 8191));
        rq.playing = $urandom_range(1);
        pick = $urandom_range(99);
        rq.bpm = (pick < 10) ? '0 : (pick < 20) ? BPM_W'($urandom()) :
                 BPM_W'($urandom_range(30 << 16, 300 << 16));
        if ($urandom_range(3) == 0)
        begin
            rq.ppq = PPQ_W'({$urandom(), $urandom()});
        end
        else
        begin
            rq.ppq = PPQ_W'(longint'($urandom_range(0, 2000 << 16)) - longint'(1000 << 16));
        end
        return rq;
    endfunction

    initial
    begin
        bit [OUT_W-1:0] want;
        lfo_req_t       rq;
        errors = 0;
        cycles = 0;
        send_idle = 1'b0;
        recv_stall = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        sample_count = '0;
        host_playing = 1'b0;
        host_bpm_q16 = '0;
        host_ppq_q16 = '0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_enabled = 1'b0;
        m_shape = SHAPE_OFF;
        m_sync = 1'b0;
        m_div = 3'd2;
        m_flavor = 2'd0;
        m_rate = 32'd65536;
        m_offset = '0;
        m_fs = 19'd48000;
        m_phase = '0;

        // directed: defaults, phase reset, every shape, sync paths, extremes
        add_req(0, 100, 0, 0, 0, 1, 0);
        add_req(1, 0, 0, 0, 0, 1, 0);
        add_cfg(CFG_ENABLED, 1);
        add_cfg(CFG_WAVE_SHAPE, SHAPE_SQUARE);
        add_req(0, 0, 0, 0, 0, 1, 65536);
        add_cfg(CFG_WAVE_SHAPE, SHAPE_SAW);
        add_req(0, 0, 0, 0, 0, 1, 0);
        add_req(0, 4096, 0, 0, 0, 0, 0);
        add_req(0, 8191, 0, 0, 0, 0, 0);
        add_cfg(CFG_WAVE_SHAPE, SHAPE_SINE);
        add_req(0, 1000, 1, 0, 0, 0, 0);
        add_cfg(CFG_WAVE_SHAPE, SHAPE_TRIANGLE);
        add_cfg(CFG_TEMPO_SYNC, 1);
        add_req(0, 512, 1, 0, 0, 0, 0);
        add_req(0, 512, 0, 120 << 16, 0, 0, 0);
        add_req(0, 256, 1, 120 << 16, 48'd5 << 16, 0, 0);
        add_req(0, 4096, 1, 26'h3FF_FFFF, 48'h8000_0000_0000, 0, 0);
        add_req(0, 1, 1, 90 << 16, 48'h7FFF_FFFF_FFFF, 0, 0);
        add_req(0, 0, 1, 90 << 16, 48'hFFFF_FFFF_0000, 0, 0);
        add_cfg(CFG_NOTE_DIV, DIV_BEAT_ALIAS);
        add_cfg(CFG_NOTE_FLAV, 3);
        add_req(0, 300, 0, 140 << 16, 0, 0, 0);
        add_cfg(CFG_NOTE_DIV, 6);
        add_cfg(CFG_NOTE_FLAV, FLAVOR_DOTTED);
        add_req(0, 300, 1, 140 << 16, 48'd77 << 16, 0, 0);
        add_cfg(CFG_NOTE_DIV, 0);
        add_cfg(CFG_NOTE_FLAV, FLAVOR_TRIPLET);
        add_req(0, 4096, 0, 26'h3FF_FFFF, 0, 0, 0);
        add_cfg(CFG_WAVE_SHAPE, 5);
        add_req(0, 100, 0, 0, 0, 1, 0);
        add_cfg(CFG_WAVE_SHAPE, SHAPE_SINE);
        add_cfg(CFG_TEMPO_SYNC, 0);
        add_cfg(CFG_PHASE_OFS, 16'hFFFF);
        add_cfg(CFG_SAMPLE_RT, 0);
        add_req(0, 777, 0, 0, 0, 0, 0);
        add_cfg(CFG_SAMPLE_RT, 384000);
        add_cfg(CFG_FREE_RATE, 32'hFFFF_FFFF);
        add_req(0, 4095, 0, 0, 0, 0, 0);
        add_cfg(CFG_SAMPLE_RT, 19'h7FFFF);
        add_cfg(CFG_FREE_RATE, 0);
        add_req(0, 4096, 0, 0, 0, 0, 0);
        add_cfg(CFG_ENABLED, 0);
        add_req(0, 4096, 0, 0, 0, 1, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(directed[i].idx, directed[i].data);
                end_writes();
            end
            else
            begin
                if (directed[i].has_exp)
                begin
                    // hand-read value must agree with the predictor before it runs
                    drain();
                    want = directed[i].exp_val;
                    send_request(directed[i].rq);
                    in_valid <= 1'b0;
                    @(posedge clk);
                    if (lfo_expected.size() != 0 && lfo_expected[$] != want)
                    begin
                        report_mismatch("directed table", lfo_expected[$], want);
                    end
                end
                else
                begin
                    send_request(directed[i].rq);
                end
            end
        end

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1) || (ph == 3);
            recv_stall = (ph == 2) || (ph == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 53 == 0)
                begin
                    drain();
                    random_settings();
                end
                rq = random_request();
                send_request(rq);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && lfo_expected.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
